### src/ebde_pkg.sv
// ebde_pkg: shared types and constants for the ECG beat detector / encoder.
// Used by the front, back and top level; no dependencies.
package ebde_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_REFRACTORY = 2'd0;
  localparam logic [1:0] CFG_LED_HOLD   = 2'd1;
  localparam logic [1:0] CFG_RATIO      = 2'd2;

  // Configuration reset values
  localparam logic [15:0] REFRACTORY_RST = 16'd200;
  localparam logic [15:0] LED_HOLD_RST   = 16'd80;
  localparam logic [9:0]  RATIO_RST      = 10'd384;

  // Word tags
  localparam logic [15:0] TAG_SAMPLE = 16'h8000;
  localparam logic [15:0] TAG_PULSE  = 16'hA000;

  typedef struct packed {
    logic [15:0] refractory_ms;
    logic [15:0] led_hold_ms;
    logic [9:0]  ratio_q8;
  } cfg_t;

  // One classified sample handed from front to back
  typedef struct packed {
    logic [15:0] sample_word;
    logic        beat;
    logic [15:0] interval;
    logic        led;
  } entry_t;

endpackage

### src/ebde_if.sv
// ebde_if: valid/ready channel interfaces for samples in and words out.
// No dependencies.
interface ebde_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [31:0]            now_ms;

  modport source (output valid, sample, now_ms, input ready);
  modport sink   (input valid, sample, now_ms, output ready);
endinterface

interface ebde_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        is_pulse;
  logic        led_on;
  logic        last;

  modport source (output valid, word, is_pulse, led_on, last, input ready);
  modport sink   (input valid, word, is_pulse, led_on, last, output ready);
endinterface

### src/ebde_ram.sv
// ebde_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ebde_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ebde_fifo.sv
// ebde_fifo: short queue of classified samples between front and back.
// Depends on ebde_pkg (entry_t).
module ebde_fifo
  import ebde_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/ebde_front.sv
// ebde_front: accepts samples, keeps the moving average, detects beats and
// drives the LED state. Depends on ebde_pkg, ebde_if and ebde_ram.
module ebde_front
  import ebde_pkg::*;
#(
  parameter int SAMPLE_WINDOW = 50,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic     clk,
  input  logic     rst,
  ebde_in_if.sink  samples,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_data
);

  localparam int SLOT_W = $clog2(SAMPLE_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
  // floor(sum / SAMPLE_WINDOW) as (sum * RECIP) >> SHIFT, exact for any SUM_W-bit sum
  localparam int SHIFT  = SUM_W + SLOT_W;
  localparam int MW     = SUM_W + 2;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(SAMPLE_WINDOW) - 64'd1) / 64'(SAMPLE_WINDOW);
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
  localparam int PROD_W = SUM_W + MW;
  localparam int THR_W  = SAMPLE_BITS + 10;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SUM,
    F_AVG,
    F_THR,
    F_DEC
  } fstate_t;

  fstate_t                  state;
  logic [SAMPLE_BITS-1:0]   v;
  logic [31:0]              now;
  logic [31:0]              dt;
  logic [SLOT_W-1:0]        slot;
  logic [SUM_W-1:0]         sum;
  logic [SAMPLE_WINDOW-1:0] filled;
  logic [PROD_W-1:0]        prod;
  logic [THR_W-1:0]         thr;
  logic [31:0]              beat_time;
  logic                     led;

  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]   old;
  logic [SAMPLE_BITS-1:0]   avg;
  logic [THR_W-1:0]         lhs;
  logic                     past_refr;
  logic                     past_hold;
  logic                     beat;
  logic                     led_next;
  logic [15:0]              v16;

  assign samples.ready = (state == F_IDLE) && !q_full;

  // Sample window memory; read address sits on the current slot
  ebde_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SAMPLE_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (state == F_SUM),
    .waddr (slot),
    .wdata (v),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // Entries never written read as zero
  assign old = filled[slot] ? ram_rdata : '0;
  assign avg = prod[SHIFT +: SAMPLE_BITS];

  // Beat decision
  assign lhs       = {2'b00, v, 8'h00};
  assign past_refr = dt > {16'h0000, cfg.refractory_ms};
  assign past_hold = dt > {16'h0000, cfg.led_hold_ms};
  assign beat      = past_refr && (lhs > thr);

  always_comb begin
    led_next = led;
    if (past_refr) begin
      led_next = beat;
    end else if (past_hold) begin
      led_next = 1'b0;
    end
  end

  // Queue entry
  assign v16  = 16'(v);
  assign push = (state == F_DEC);
  always_comb begin
    push_data.sample_word = TAG_SAMPLE | {3'b000, v16[11:7], 1'b0, v16[6:0]};
    push_data.beat        = beat;
    push_data.interval    = (dt[31:16] != 16'h0000) ? 16'hFFFF : dt[15:0];
    push_data.led         = led_next;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      slot      <= '0;
      sum       <= '0;
      filled    <= '0;
      beat_time <= '0;
      led       <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (samples.valid && samples.ready) begin
            v     <= samples.sample;
            now   <= samples.now_ms;
            state <= F_SUM;
          end
        end
        F_SUM: begin
          sum          <= sum - SUM_W'(old) + SUM_W'(v);
          filled[slot] <= 1'b1;
          slot         <= (slot == SLOT_W'(SAMPLE_WINDOW - 1)) ? '0 : slot + 1'b1;
          dt           <= now - beat_time;
          state        <= F_AVG;
        end
        F_AVG: begin
          prod  <= PROD_W'(sum) * PROD_W'(RECIP);
          state <= F_THR;
        end
        F_THR: begin
          thr   <= THR_W'(cfg.ratio_q8) * THR_W'(avg);
          state <= F_DEC;
        end
        F_DEC: begin
          led <= led_next;
          if (beat) begin
            beat_time <= now;
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### src/ebde_back.sv
// ebde_back: emits sample words, keeps the beat interval average and divides
// it into a pulse rate. Depends on ebde_pkg and ebde_if.
module ebde_back
  import ebde_pkg::*;
#(
  parameter int INTERVAL_WINDOW = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  entry_t    pop_data,
  output logic      pop,
  ebde_out_if.source words
);

  localparam int ISLOT_W = $clog2(INTERVAL_WINDOW);
  localparam int ISUM_W  = 16 + ISLOT_W;
  // floor(isum / INTERVAL_WINDOW) as (isum * IRECIP) >> ISHIFT
  localparam int ISHIFT  = ISUM_W + ISLOT_W;
  localparam int IMW     = ISUM_W + 2;
  localparam logic [63:0] IRECIP64 =
    ((64'd1 << ISHIFT) + 64'(INTERVAL_WINDOW) - 64'd1) / 64'(INTERVAL_WINDOW);
  localparam logic [IMW-1:0] IRECIP = IRECIP64[IMW-1:0];
  localparam int IPROD_W = ISUM_W + IMW;
  localparam logic [15:0] DIVIDEND = 16'd60000;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SWORD,
    B_IUPD,
    B_IAVG,
    B_DSET,
    B_DIV,
    B_PWORD
  } bstate_t;

  bstate_t              state;
  entry_t               ent;
  logic [15:0]          ivals [INTERVAL_WINDOW];
  logic [ISLOT_W-1:0]   islot;
  logic [ISUM_W-1:0]    isum;
  logic [IPROD_W-1:0]   iprod;
  logic [15:0]          divisor;
  logic [15:0]          rem;
  logic [15:0]          quo;
  logic [3:0]           bit_idx;

  logic                 out_free;
  logic                 emit;
  logic [16:0]          trial;
  logic                 fits;
  logic [7:0]           rate;

  assign out_free = !words.valid || words.ready;
  assign emit     = ((state == B_SWORD) || (state == B_PWORD)) && out_free;
  assign pop      = (state == B_IDLE) && !q_empty;

  // One restoring step: a zero divisor gives all ones, which saturates below
  assign trial = {rem, DIVIDEND[bit_idx]};
  assign fits  = trial >= {1'b0, divisor};
  assign rate  = (quo[15:8] != 8'h00) ? 8'hFF : quo[7:0];

  // Interval window, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < INTERVAL_WINDOW; i++) begin
        ivals[i] <= '0;
      end
    end else if (state == B_IUPD) begin
      ivals[islot] <= ent.interval;
    end
  end

  // Sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      islot       <= '0;
      isum        <= '0;
      words.valid <= 1'b0;
    end else begin
      if (words.valid && words.ready && !emit) begin
        words.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent   <= pop_data;
            state <= B_SWORD;
          end
        end
        B_SWORD: begin
          if (out_free) begin
            words.valid    <= 1'b1;
            words.word     <= ent.sample_word;
            words.is_pulse <= 1'b0;
            words.led_on   <= ent.led;
            words.last     <= !ent.beat;
            state          <= ent.beat ? B_IUPD : B_IDLE;
          end
        end
        B_IUPD: begin
          isum  <= isum - ISUM_W'(ivals[islot]) + ISUM_W'(ent.interval);
          islot <= (islot == ISLOT_W'(INTERVAL_WINDOW - 1)) ? '0 : islot + 1'b1;
          state <= B_IAVG;
        end
        B_IAVG: begin
          iprod <= IPROD_W'(isum) * IPROD_W'(IRECIP);
          state <= B_DSET;
        end
        B_DSET: begin
          divisor <= iprod[ISHIFT +: 16];
          rem     <= '0;
          quo     <= '0;
          bit_idx <= 4'd15;
          state   <= B_DIV;
        end
        B_DIV: begin
          rem          <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
          quo[bit_idx] <= fits;
          bit_idx      <= bit_idx - 1'b1;
          if (bit_idx == 4'd0) begin
            state <= B_PWORD;
          end
        end
        B_PWORD: begin
          if (out_free) begin
            words.valid    <= 1'b1;
            words.word     <= TAG_PULSE | {6'b000000, rate[7], 2'b00, rate[6:0]};
            words.is_pulse <= 1'b1;
            words.led_on   <= ent.led;
            words.last     <= 1'b1;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### src/ecg_beat_detector_encoder.sv
// Channel   | Dir | Payload                          | Handshake
// samples   | in  | sample, now_ms                   | valid/ready
// words     | out | word, is_pulse, led_on, last     | valid/ready
// cfg       | in  | cfg_we, cfg_index, cfg_data      | write on cfg_we
//
// Front: one sample at a time, through window RAM read, sum, reciprocal
// multiply, threshold multiply and decide. Back: a sample word, and with a
// beat a pulse word after the 16-step restoring divider for 60000 / avg.
// Reset (synchronous): config to defaults, all windows and state zero; the
// sample window RAM uses per-entry valid bits, so there is no clearing pass.
// A two-entry queue lets the front keep taking samples while words stall.
// Depends on ebde_pkg, ebde_if, ebde_ram, ebde_fifo, ebde_front, ebde_back.
module ecg_beat_detector_encoder
  import ebde_pkg::*;
#(
  parameter int SAMPLE_WINDOW   = 50,
  parameter int INTERVAL_WINDOW = 6,
  parameter int SAMPLE_BITS     = 12
) (
  input  logic        clk,
  input  logic        rst,
  ebde_in_if.sink     samples,
  ebde_out_if.source  words,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QUEUE_DEPTH = 2;

  cfg_t   cfg;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  entry_t push_data;
  entry_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.refractory_ms <= REFRACTORY_RST;
      cfg.led_hold_ms   <= LED_HOLD_RST;
      cfg.ratio_q8      <= RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFRACTORY: cfg.refractory_ms <= cfg_data;
        CFG_LED_HOLD:   cfg.led_hold_ms   <= cfg_data;
        CFG_RATIO:      cfg.ratio_q8      <= cfg_data[9:0];
        default:        ;
      endcase
    end
  end

  ebde_front #(
    .SAMPLE_WINDOW (SAMPLE_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ebde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  ebde_back #(
    .INTERVAL_WINDOW (INTERVAL_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop_data (pop_data),
    .pop      (pop),
    .words    (words)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("queue pop while empty");

  // A pulse word always closes its sample's results
  a_pulse_last: assert property (@(posedge clk) disable iff (rst)
    (words.valid && words.is_pulse) |-> words.last)
    else $error("pulse word not marked last");

  // Tag bits agree with the word kind
  a_tag: assert property (@(posedge clk) disable iff (rst)
    words.valid |-> (words.word[15:13] == (words.is_pulse ? 3'b101 : 3'b100)))
    else $error("word tag does not match is_pulse");

endmodule
